### rtl/generational_handle_table_defines.svh
// Assertion macros for the checker file of the handle table.
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GHT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication that is checked also around reset.
`define GHT_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/ght_pkg.sv
package ght_pkg;

   localparam int IDX_FIELD_W  = 8;
   localparam int GEN_FIELD_W  = 16;
   localparam int DATA_FIELD_W = 32;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_WRITE = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_BOUNDS  = 3'd1,
      STATUS_STALE   = 3'd2,
      STATUS_NULLREF = 3'd3,
      STATUS_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      command_type             command;
      logic [IDX_FIELD_W-1:0]  slot_index;
      logic [GEN_FIELD_W-1:0]  slot_generation;
      logic [DATA_FIELD_W-1:0] write_data;
   } req_item_type;

   typedef struct packed {
      status_type              status;
      logic [IDX_FIELD_W-1:0]  handle_index;
      logic [GEN_FIELD_W-1:0]  handle_generation;
      logic [DATA_FIELD_W-1:0] read_data;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic pop;
      logic execute;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pop_needed;
   } dp_status_type;

endpackage

### rtl/ght_ctrl.sv
module ght_ctrl import ght_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type stat,
   output logic          busy,
   output ctrl_cmd_type  ctrl
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      ctrl.capture = 1'b0;
      ctrl.pop     = 1'b0;
      ctrl.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.capture = 1'b1;
               state_in     = stat.pop_needed ? S_POP : S_EXEC;
            end
         end
         S_POP: begin
            // The popped index is registered at capture, so it addresses the generation table in this state.
            ctrl.pop = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ctrl.execute = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### rtl/ght_datapath.sv
module ght_datapath import ght_pkg::*; #(
   parameter int CAPACITY  = 256,
   parameter int GEN_BITS  = 16,
   parameter int DATA_BITS = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  req_item_type  req_item,
   input  ctrl_cmd_type  ctrl,
   output dp_status_type stat,
   output logic          rsp_valid,
   output rsp_item_type  rsp_item
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMPI_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;
   localparam int CMPG_W = (GEN_BITS > GEN_FIELD_W) ? GEN_BITS : GEN_FIELD_W;

   logic [GEN_BITS-1:0]  gen_mem   [CAPACITY];
   logic [DATA_BITS-1:0] data_mem  [CAPACITY];
   logic [IDX_W-1:0]     stack_mem [CAPACITY];

   req_item_type         req_ff;
   logic [CNT_W-1:0]     slots_opened_ff, slots_opened_in;
   logic [CNT_W-1:0]     free_count_ff, free_count_in;
   logic [GEN_BITS-1:0]  gen_rd_ff;
   logic [DATA_BITS-1:0] data_rd_ff;
   logic [IDX_W-1:0]     stack_rd_ff;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   logic [IDX_W-1:0]     gen_rd_addr;
   logic [IDX_W-1:0]     req_addr;
   logic [IDX_W-1:0]     req_ff_addr;
   logic                 in_bounds;
   logic                 gen_match;
   logic                 live;
   logic                 stack_empty;
   logic                 stack_full;
   logic                 can_open;

   logic                 gen_we;
   logic [IDX_W-1:0]     gen_waddr;
   logic [GEN_BITS-1:0]  gen_wdata;
   logic                 data_we;
   logic [IDX_W-1:0]     data_waddr;
   logic [DATA_BITS-1:0] data_wdata;
   logic                 stack_we;

   assign req_addr    = IDX_W'(req_item.slot_index);
   assign req_ff_addr = IDX_W'(req_ff.slot_index);
   assign gen_rd_addr = ctrl.pop ? stack_rd_ff : req_addr;

   assign stat.pop_needed = (req_item.command == CMD_ALLOC) && (free_count_ff != '0);

   // Request register and synchronous memory reads.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         req_ff      <= req_item;
         data_rd_ff  <= data_mem[req_addr];
         stack_rd_ff <= stack_mem[IDX_W'(free_count_ff - CNT_W'(1))];
      end
      if (ctrl.capture || ctrl.pop) begin
         gen_rd_ff <= gen_mem[gen_rd_addr];
      end
   end

   assign in_bounds   = CMPI_W'(req_ff.slot_index) < CMPI_W'(slots_opened_ff);
   assign gen_match   = CMPG_W'(gen_rd_ff) ==
                        (CMPG_W'(req_ff.slot_generation) & CMPG_W'({GEN_BITS{1'b1}}));
   assign live        = in_bounds && gen_match;
   assign stack_empty = (free_count_ff == '0);
   assign stack_full  = (free_count_ff == CNT_W'(CAPACITY));
   assign can_open    = (slots_opened_ff != CNT_W'(CAPACITY));

   always_comb begin
      slots_opened_in = slots_opened_ff;
      free_count_in   = free_count_ff;
      rsp_item_in     = '{status: STATUS_OK, default: '0};
      gen_we          = 1'b0;
      gen_waddr       = req_ff_addr;
      gen_wdata       = gen_rd_ff + GEN_BITS'(1);
      data_we         = 1'b0;
      data_waddr      = req_ff_addr;
      data_wdata      = DATA_BITS'(req_ff.write_data);
      stack_we        = 1'b0;
      unique case (req_ff.command)
         CMD_ALLOC: begin
            priority if (!stack_empty) begin
               free_count_in                 = free_count_ff - CNT_W'(1);
               data_we                       = 1'b1;
               data_waddr                    = stack_rd_ff;
               data_wdata                    = '0;
               rsp_item_in.handle_index      = IDX_FIELD_W'(stack_rd_ff);
               rsp_item_in.handle_generation = GEN_FIELD_W'(gen_rd_ff);
            end else if (can_open) begin
               // A fresh slot starts at generation zero with zero data.
               slots_opened_in          = slots_opened_ff + CNT_W'(1);
               gen_we                   = 1'b1;
               gen_waddr                = IDX_W'(slots_opened_ff);
               gen_wdata                = '0;
               data_we                  = 1'b1;
               data_waddr               = IDX_W'(slots_opened_ff);
               data_wdata               = '0;
               rsp_item_in.handle_index = IDX_FIELD_W'(slots_opened_ff);
            end else begin
               rsp_item_in.status = STATUS_FULL;
            end
         end
         CMD_FREE: begin
            priority if (!in_bounds) begin
               rsp_item_in.status = STATUS_BOUNDS;
            end else if (!gen_match) begin
               rsp_item_in.status = STATUS_STALE;
            end else if (stack_full) begin
               rsp_item_in.status = STATUS_FULL;
            end else begin
               gen_we        = 1'b1;
               stack_we      = 1'b1;
               free_count_in = free_count_ff + CNT_W'(1);
            end
         end
         CMD_READ: begin
            if (live) begin
               rsp_item_in.read_data = DATA_FIELD_W'(data_rd_ff);
            end else begin
               rsp_item_in.status = STATUS_NULLREF;
            end
         end
         CMD_WRITE: begin
            if (live) begin
               data_we = 1'b1;
            end else begin
               rsp_item_in.status = STATUS_NULLREF;
            end
         end
         default: rsp_item_in.status = STATUS_NULLREF;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.execute) begin
         if (gen_we) begin
            gen_mem[gen_waddr] <= gen_wdata;
         end
         if (data_we) begin
            data_mem[data_waddr] <= data_wdata;
         end
         if (stack_we) begin
            stack_mem[IDX_W'(free_count_ff)] <= req_ff_addr;
         end
         rsp_item_ff <= rsp_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_opened_ff <= '0;
         free_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.execute;
         if (ctrl.execute) begin
            slots_opened_ff <= slots_opened_in;
            free_count_ff   <= free_count_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### rtl/generational_handle_table.sv
// Free, read, write and an allocate that opens a slot or reports full go from idle to the execute
// state; the result strobe is registered from execute, high once the block is idle again, where
// the next item can be accepted too. Allocate from the free stack passes through a pop state
// first: the popped index is read from the stack before it addresses the generation memory.
// The rate is set by the synchronous-read memories (read, then update). Results cannot be stalled.
// Reset is synchronous and clears the slot and free counts and the strobe, never the memories.
module generational_handle_table import ght_pkg::*; #(
   parameter int CAPACITY  = 256,
   parameter int GEN_BITS  = 16,
   parameter int DATA_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   ctrl_cmd_type  ctrl;
   dp_status_type stat;

   ght_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   ght_datapath #(
      .CAPACITY  (CAPACITY),
      .GEN_BITS  (GEN_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/ght_checker.sv
`include "generational_handle_table_defines.svh"

module ght_checker import ght_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input req_item_type req_item,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   // An accepted item always makes the block busy in the next cycle.
   `GHT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // Every command but allocate must return a result after acceptance.
   `GHT_ASSERT_IMP(a_rsp_latency, clock, reset, start && !busy && (req_item.command != CMD_ALLOC), ##2 rsp_valid, "missing result")

   // Results are never back to back, since each item passes through the execute state after idle.
   `GHT_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_valid, !rsp_valid, "results back to back")

   // A failed command returns all-zero payload fields.
   `GHT_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && (rsp_item.status != STATUS_OK), (rsp_item.handle_index == '0) && (rsp_item.handle_generation == '0) && (rsp_item.read_data == '0), "nonzero payload on failure")

   // The cycle after reset the block is idle and silent.
   `GHT_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) && !reset, !busy && !rsp_valid, "not idle after reset")

endmodule

bind generational_handle_table ght_checker u_checker (.*);
